>>> rtl/core/clr_pkg.sv
// clr_pkg: shared widths, register and command codes, and the types passed
// between the front end, the command queue and the stepper of the line rasterizer
// no dependencies
package clr_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W = 16;
    localparam int DELTA_W = COORD_W + 1;
    localparam int ERR_W   = COORD_W + 2;
    localparam int CALC_W  = COORD_W + 3;

    // configuration widths
    localparam int CANVAS_W = 13;
    localparam int BPP_W    = 3;
    localparam int STRIDE_W = 16;
    localparam int COLOR_W  = 24;
    localparam int ADDR_W   = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // address arithmetic widths
    localparam int PX_W  = COORD_W + BPP_W;
    localparam int PY_W  = COORD_W + STRIDE_W;
    localparam int SUM_W = ((PX_W > PY_W) ? ((PX_W > ADDR_W) ? PX_W : ADDR_W)
                                          : ((PY_W > ADDR_W) ? PY_W : ADDR_W)) + 1;
    localparam int CMP_W = (COORD_W > CANVAS_W) ? COORD_W : CANVAS_W;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [CANVAS_W-1:0] CANVAS_RESET = CANVAS_W'(1024);
    localparam logic [BPP_W-1:0]    BPP_RESET    = BPP_W'(4);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(4096);
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = {COLOR_W{1'b1}};

    // command codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CANVAS_SIZE     = 3'd0,
        REG_BYTES_PER_PIXEL = 3'd1,
        REG_LINE_STRIDE     = 3'd2,
        REG_PIXEL_COLOR     = 3'd3
    } clr_reg_t;

    // configuration seen by the stepper
    typedef struct packed {
        logic [CANVAS_W-1:0] canvas_size;
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic [STRIDE_W-1:0] line_stride;
        logic [COLOR_W-1:0]  pixel_color;
    } clr_cfg_t;

    // classified command, one queue entry
    typedef struct packed {
        logic                      is_start;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] goal_x;
        logic signed [COORD_W-1:0] goal_y;
        logic [DELTA_W-1:0]        delta_x;
        logic [DELTA_W-1:0]        delta_y;
        logic                      x_neg;
        logic                      y_neg;
        logic signed [ERR_W-1:0]   error_init;
        logic                      at_goal;
    } clr_cmd_t;

endpackage

>>> rtl/core/clr_front.sv
// clr_front: classifies an incoming item and works out the line setup
// (deltas, step directions, initial error term); depends on clr_pkg
module clr_front
    import clr_pkg::*;
(
    input  logic                      func,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    output clr_cmd_t                  cmd
);

    logic signed [DELTA_W-1:0] diff_x;
    logic signed [DELTA_W-1:0] diff_y;
    logic [DELTA_W-1:0]        abs_x;
    logic [DELTA_W-1:0]        abs_y;
    logic [DELTA_W-1:0]        half_x;
    logic [DELTA_W-1:0]        half_y;

    // signed differences one bit wider than the coordinates
    assign diff_x = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    assign diff_y = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};

    assign abs_x = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
    assign abs_y = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);

    // halving truncates toward zero
    assign half_x = abs_x >> 1;
    assign half_y = abs_y >> 1;

    // setup fields
    always_comb
    begin
        cmd.is_start = (func == FUNC_START);
        cmd.start_x  = start_x;
        cmd.start_y  = start_y;
        cmd.goal_x   = end_x;
        cmd.goal_y   = end_y;
        cmd.delta_x  = abs_x;
        cmd.delta_y  = abs_y;
        cmd.x_neg    = diff_x[DELTA_W-1] || (diff_x == '0);
        cmd.y_neg    = diff_y[DELTA_W-1] || (diff_y == '0);
        if (abs_x > abs_y)
        begin
            cmd.error_init = $signed({1'b0, half_x});
        end
        else
        begin
            cmd.error_init = -$signed({1'b0, half_y});
        end
        cmd.at_goal = (start_x == end_x) && (start_y == end_y);
    end

endmodule

>>> rtl/core/clr_queue.sv
// clr_queue: short command queue between the front end and the stepper
// depends on clr_pkg
module clr_queue
    import clr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  clr_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output clr_cmd_t head_cmd
);

    clr_cmd_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/clr_back.sv
// clr_back: line stepper holding the line state, then clip test, address
// products and address sum in a three-stage pipeline; depends on clr_pkg
module clr_back
    import clr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  clr_cfg_t                  cfg,
    input  logic                      cmd_valid,
    input  clr_cmd_t                  cmd,
    output logic                      cmd_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic [ADDR_W-1:0]         byte_address,
    output logic                      write_enable,
    output logic [COLOR_W-1:0]        color_out,
    output logic                      last
);

    // line state
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_W-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_W-1:0] goal_y_reg, goal_y_next;
    logic [DELTA_W-1:0]        delta_x_reg, delta_x_next;
    logic [DELTA_W-1:0]        delta_y_reg, delta_y_next;
    logic                      x_neg_reg, x_neg_next;
    logic                      y_neg_reg, y_neg_next;
    logic signed [ERR_W-1:0]   error_reg, error_next;
    logic                      finished_reg, finished_next;

    // stage 1: point
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_x_next;
    logic signed [COORD_W-1:0] s1_y_reg, s1_y_next;
    logic                      s1_draw_reg, s1_draw_next;
    logic                      s1_last_reg, s1_last_next;

    // stage 2: clip and products
    logic                      s2_valid_reg;
    logic signed [COORD_W-1:0] s2_x_reg;
    logic signed [COORD_W-1:0] s2_y_reg;
    logic                      s2_inside_reg, s2_inside_next;
    logic                      s2_last_reg;
    logic [PX_W-1:0]           s2_prod_x_reg, s2_prod_x_next;
    logic [PY_W-1:0]           s2_prod_y_reg, s2_prod_y_next;

    // output stage
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic [ADDR_W-1:0]         out_addr_reg, out_addr_next;
    logic                      out_we_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic                      out_last_reg;

    logic                      out_ready;
    logic                      s2_ready;
    logic                      s1_ready;

    logic signed [CALC_W-1:0]  e_ext;
    logic signed [CALC_W-1:0]  dx_ext;
    logic signed [CALC_W-1:0]  dy_ext;
    logic signed [CALC_W-1:0]  sum_x;
    logic signed [CALC_W-1:0]  diff_y;
    logic signed [CALC_W-1:0]  err_calc;
    logic                      move_x;
    logic                      move_y;
    logic signed [COORD_W-1:0] step_x;
    logic signed [COORD_W-1:0] step_y;
    logic [SUM_W-1:0]          addr_sum;

    // ready chain, each stage fills its bubble
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign cmd_pop   = cmd_valid && s1_ready;

    // error term decisions
    assign e_ext  = CALC_W'(error_reg);
    assign dx_ext = $signed(CALC_W'(delta_x_reg));
    assign dy_ext = $signed(CALC_W'(delta_y_reg));
    assign sum_x  = e_ext + dx_ext;
    assign diff_y = e_ext - dy_ext;
    assign move_x = !sum_x[CALC_W-1] && (sum_x != '0);
    assign move_y = diff_y[CALC_W-1];

    always_comb
    begin
        err_calc = e_ext;
        if (move_x)
        begin
            err_calc = err_calc - dy_ext;
        end
        if (move_y)
        begin
            err_calc = err_calc + dx_ext;
        end
    end

    assign step_x = !move_x ? cur_x_reg : (x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1);
    assign step_y = !move_y ? cur_y_reg : (y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1);

    // next line state and stage 1 point
    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        goal_x_next   = goal_x_reg;
        goal_y_next   = goal_y_reg;
        delta_x_next  = delta_x_reg;
        delta_y_next  = delta_y_reg;
        x_neg_next    = x_neg_reg;
        y_neg_next    = y_neg_reg;
        error_next    = error_reg;
        finished_next = finished_reg;
        s1_x_next     = cur_x_reg;
        s1_y_next     = cur_y_reg;
        s1_draw_next  = 1'b0;
        s1_last_next  = 1'b1;
        if (cmd.is_start)
        begin
            cur_x_next    = cmd.start_x;
            cur_y_next    = cmd.start_y;
            goal_x_next   = cmd.goal_x;
            goal_y_next   = cmd.goal_y;
            delta_x_next  = cmd.delta_x;
            delta_y_next  = cmd.delta_y;
            x_neg_next    = cmd.x_neg;
            y_neg_next    = cmd.y_neg;
            error_next    = cmd.error_init;
            finished_next = cmd.at_goal;
            s1_x_next     = cmd.start_x;
            s1_y_next     = cmd.start_y;
            s1_draw_next  = 1'b1;
            s1_last_next  = cmd.at_goal;
        end
        else if (!finished_reg)
        begin
            cur_x_next    = step_x;
            cur_y_next    = step_y;
            error_next    = ERR_W'(err_calc);
            finished_next = (step_x == goal_x_reg) && (step_y == goal_y_reg);
            s1_x_next     = step_x;
            s1_y_next     = step_y;
            s1_draw_next  = 1'b1;
            s1_last_next  = (step_x == goal_x_reg) && (step_y == goal_y_reg);
        end
    end

    // clip test and address products
    assign s2_inside_next = s1_draw_reg && !s1_x_reg[COORD_W-1] && !s1_y_reg[COORD_W-1]
                          && (CMP_W'($unsigned(s1_x_reg)) < CMP_W'(cfg.canvas_size))
                          && (CMP_W'($unsigned(s1_y_reg)) < CMP_W'(cfg.canvas_size));
    assign s2_prod_x_next = PX_W'($unsigned(s1_x_reg)) * PX_W'(cfg.bytes_per_pixel);
    assign s2_prod_y_next = PY_W'($unsigned(s1_y_reg)) * PY_W'(cfg.line_stride);

    // address sum, zero outside the canvas
    assign addr_sum      = SUM_W'(s2_prod_x_reg) + SUM_W'(s2_prod_y_reg);
    assign out_addr_next = s2_inside_reg ? addr_sum[ADDR_W-1:0] : '0;

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            delta_x_reg  <= '0;
            delta_y_reg  <= '0;
            x_neg_reg    <= 1'b0;
            y_neg_reg    <= 1'b0;
            error_reg    <= '0;
            finished_reg <= 1'b1;
        end
        else if (cmd_pop)
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            goal_x_reg   <= goal_x_next;
            goal_y_reg   <= goal_y_next;
            delta_x_reg  <= delta_x_next;
            delta_y_reg  <= delta_y_next;
            x_neg_reg    <= x_neg_next;
            y_neg_reg    <= y_neg_next;
            error_reg    <= error_next;
            finished_reg <= finished_next;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
            s1_draw_reg <= s1_draw_next;
            s1_last_reg <= s1_last_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_inside_reg <= s2_inside_next;
            s2_last_reg   <= s1_last_reg;
            s2_prod_x_reg <= s2_prod_x_next;
            s2_prod_y_reg <= s2_prod_y_next;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_x_reg     <= s2_x_reg;
            out_y_reg     <= s2_y_reg;
            out_addr_reg  <= out_addr_next;
            out_we_reg    <= s2_inside_reg;
            out_color_reg <= cfg.pixel_color;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = out_x_reg;
    assign point_y      = out_y_reg;
    assign byte_address = out_addr_reg;
    assign write_enable = out_we_reg;
    assign color_out    = out_color_reg;
    assign last         = out_last_reg;

    // a repeated endpoint is never drawn and always flagged last
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_draw_reg) |-> s1_last_reg)
        else $error("undrawn point without last flag");

    // an enabled write lies inside the canvas
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_we_reg) |->
            (!out_x_reg[COORD_W-1] && !out_y_reg[COORD_W-1]
             && (CMP_W'($unsigned(out_x_reg)) < CMP_W'(cfg.canvas_size))
             && (CMP_W'($unsigned(out_y_reg)) < CMP_W'(cfg.canvas_size))))
        else $error("write enabled outside canvas");

    // clipped points carry a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_we_reg) |-> (out_addr_reg == '0))
        else $error("nonzero address on clipped point");

    // once a line reaches its end the stepper holds its position
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && finished_reg && !cmd.is_start) |=>
            ($stable(cur_x_reg) && $stable(cur_y_reg) && finished_reg))
        else $error("stepper moved after line end");

endmodule

>>> rtl/core/clipped_line_rasterizer.sv
// clipped_line_rasterizer: top level with configuration registers, front end,
// command queue and stepper; depends on clr_pkg, clr_front, clr_queue, clr_back
// an accepted item is registered in the queue, then in stage 1, stage 2 and the output register
// throughput: one item per cycle while out_stall does not hold the pipeline
// a two-entry command queue takes items while results wait on the output side
// reset: asynchronous, active low; registers return to canvas 1024, 4 bytes per pixel,
// stride 4096, white; no line is active, so a step repeats point (0, 0) undrawn
module clipped_line_rasterizer
    import clr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic [ADDR_W-1:0]         byte_address,
    output logic                      write_enable,
    output logic [COLOR_W-1:0]        color_out,
    output logic                      last
);

    logic [CANVAS_W-1:0] canvas_size_reg;
    logic [BPP_W-1:0]    bytes_per_pixel_reg;
    logic [STRIDE_W-1:0] line_stride_reg;
    logic [COLOR_W-1:0]  pixel_color_reg;
    clr_cfg_t            cfg;
    clr_cmd_t            front_cmd;
    clr_cmd_t            head_cmd;
    logic                queue_full;
    logic                head_valid;
    logic                cmd_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_size_reg     <= CANVAS_RESET;
            bytes_per_pixel_reg <= BPP_RESET;
            line_stride_reg     <= STRIDE_RESET;
            pixel_color_reg     <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CANVAS_SIZE:     canvas_size_reg     <= cfg_data[CANVAS_W-1:0];
                REG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[BPP_W-1:0];
                REG_LINE_STRIDE:     line_stride_reg     <= cfg_data[STRIDE_W-1:0];
                REG_PIXEL_COLOR:     pixel_color_reg     <= cfg_data[COLOR_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.canvas_size     = canvas_size_reg;
    assign cfg.bytes_per_pixel = bytes_per_pixel_reg;
    assign cfg.line_stride     = line_stride_reg;
    assign cfg.pixel_color     = pixel_color_reg;

    assign in_stall = queue_full;

    // line setup
    clr_front u_front (
        .func    (func),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .cmd     (front_cmd)
    );

    // command queue
    clr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // stepper and address pipeline
    clr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .byte_address (byte_address),
        .write_enable (write_enable),
        .color_out    (color_out),
        .last         (last)
    );

endmodule

>>> test/clipped_line_rasterizer_test.sv
// clipped_line_rasterizer_test: self-checking bench that feeds start and step items,
// predicts every point with its own line stepper and compares each result field by field
// depends on clr_pkg and clipped_line_rasterizer
module clipped_line_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASE_COUNT   = 7;

    // register indexes past the last real register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    // one expected point
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ADDR_W-1:0]         addr;
        logic                      we;
        logic [COLOR_W-1:0]        color;
        logic                      last;
    } line_point_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      func;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [ADDR_W-1:0]         byte_address;
    logic                      write_enable;
    logic [COLOR_W-1:0]        color_out;
    logic                      last;

    // stepper model state and register copies
    int   pos_x, pos_y, tgt_x, tgt_y;
    int   span_x, span_y, err_acc;
    logic x_back, y_back, line_done;
    int   cfg_canvas, cfg_bpp, cfg_stride;
    logic [COLOR_W-1:0] cfg_color;

    line_point_t expected_points[$];

    // bookkeeping
    logic traffic_gaps = 1'b0;
    int   stall_burst  = 0;
    int   quiet_cycles = 0;
    int   items_sent   = 0;
    int   lines_started = 0;
    int   points_checked = 0;
    int   settings_used = 0;
    int   mismatches   = 0;

    clipped_line_rasterizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .byte_address (byte_address),
        .write_enable (write_enable),
        .color_out    (color_out),
        .last         (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // model state after reset
    task automatic clear_stepper();
        pos_x = 0;
        pos_y = 0;
        tgt_x = 0;
        tgt_y = 0;
        span_x = 0;
        span_y = 0;
        err_acc = 0;
        x_back = 1'b0;
        y_back = 1'b0;
        line_done = 1'b1;
        cfg_canvas = int'(CANVAS_RESET);
        cfg_bpp = int'(BPP_RESET);
        cfg_stride = int'(STRIDE_RESET);
        cfg_color = COLOR_RESET;
    endtask

    // advance the model by one accepted item and queue the point it yields
    task automatic predict_point(input logic fn,
                                 input logic signed [COORD_W-1:0] sx, sy, ex, ey);
        int          prev_err;
        logic        drawable, at_end, in_canvas;
        longint      offset;
        line_point_t pt;
        drawable = 1'b1;
        if (fn == FUNC_START)
        begin
            pos_x = sx;
            pos_y = sy;
            tgt_x = ex;
            tgt_y = ey;
            span_x = (tgt_x > pos_x) ? tgt_x - pos_x : pos_x - tgt_x;
            span_y = (tgt_y > pos_y) ? tgt_y - pos_y : pos_y - tgt_y;
            x_back = !(pos_x < tgt_x);
            y_back = !(pos_y < tgt_y);
            // halving truncates toward zero
            err_acc = ((span_x > span_y) ? span_x : -span_y) / 2;
            at_end = (pos_x == tgt_x) && (pos_y == tgt_y);
            line_done = at_end;
            lines_started++;
        end
        else if (line_done)
        begin
            // past the end: endpoint again, undrawn
            drawable = 1'b0;
            at_end = 1'b1;
        end
        else
        begin
            prev_err = err_acc;
            if (prev_err > -span_x)
            begin
                err_acc -= span_y;
                pos_x += x_back ? -1 : 1;
            end
            if (prev_err < span_y)
            begin
                err_acc += span_x;
                pos_y += y_back ? -1 : 1;
            end
            at_end = (pos_x == tgt_x) && (pos_y == tgt_y);
            line_done = at_end;
        end
        // clip and form the address
        in_canvas = drawable && pos_x >= 0 && pos_y >= 0 &&
                    pos_x < cfg_canvas && pos_y < cfg_canvas;
        offset = in_canvas ? longint'(pos_x) * cfg_bpp + longint'(pos_y) * cfg_stride : 0;
        pt.x = pos_x[COORD_W-1:0];
        pt.y = pos_y[COORD_W-1:0];
        pt.addr = offset[ADDR_W-1:0];
        pt.we = in_canvas;
        pt.color = cfg_color;
        pt.last = at_end;
        expected_points.push_back(pt);
    endtask

    // drive one item and wait until it is taken
    task automatic send_item(input logic fn, input logic signed [COORD_W-1:0] sx, sy, ex, ey);
        int gap;
        gap = (traffic_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        do
            @(posedge clk);
        while (in_stall);
        predict_point(fn, sx, sy, ex, ey);
        items_sent++;
    endtask

    function automatic logic signed [COORD_W-1:0] rand_word();
        return COORD_W'($urandom);
    endfunction

    // coordinate near the canvas, a few pixels past each border
    function automatic logic signed [COORD_W-1:0] near_canvas();
        return COORD_W'(int'($urandom_range(0, cfg_canvas + 8)) - 4);
    endfunction

    // steps from start to end: the longer axis
    function automatic int line_steps(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
        int ax, ay;
        ax = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        ay = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        return (ax > ay) ? ax : ay;
    endfunction

    // start item followed by step items with junk in the unused fields
    task automatic trace_line(input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                              input int steps);
        send_item(FUNC_START, sx, sy, ex, ey);
        repeat (steps) send_item(FUNC_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    // stop sending and let every point drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, mirrored into the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CANVAS_SIZE:     cfg_canvas = int'(data[CANVAS_W-1:0]);
            REG_BYTES_PER_PIXEL: cfg_bpp = int'(data[BPP_W-1:0]);
            REG_LINE_STRIDE:     cfg_stride = int'(data[STRIDE_W-1:0]);
            REG_PIXEL_COLOR:     cfg_color = data[COLOR_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] canvas, bpp, stride, color);
        write_reg(REG_CANVAS_SIZE, canvas);
        write_reg(REG_BYTES_PER_PIXEL, bpp);
        write_reg(REG_LINE_STRIDE, stride);
        write_reg(REG_PIXEL_COLOR, color);
        settings_used++;
    endtask

    // step with no line active, then a single-point line and a step past it
    task automatic test_after_reset();
        send_item(FUNC_STEP, rand_word(), rand_word(), rand_word(), rand_word());
        trace_line(16'sd5, 16'sd5, 16'sd5, 16'sd5, 1);
    endtask

    // shallow, steep and reversed lines, and the coordinate extremes
    task automatic test_line_shapes();
        trace_line(16'sd0, 16'sd0, 16'sd3, 16'sd1, 3);
        trace_line(16'sd2, 16'sd0, 16'sd0, 16'sd5, 2);
        trace_line(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1);
        trace_line(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 0);
    endtask

    // points just inside and just outside the default canvas
    task automatic test_canvas_borders();
        trace_line(16'sd1023, 16'sd1023, 16'sd1024, 16'sd1024, 1);
        trace_line(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1);
    endtask

    // address wrap, zero canvas, zero pixel size and stride, writes to spare indexes
    task automatic test_register_extremes();
        wait_idle();
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++)
            write_reg(CFG_IDX_W'(idx), 24'h000000);
        trace_line(16'sd8190, 16'sd8190, 16'sd8189, 16'sd8189, 1);
        wait_idle();
        set_config(24'd0, 24'd0, 24'd0, 24'h5A5A5A);
        trace_line(16'sd0, 16'sd0, 16'sd1, 16'sd1, 1);
        wait_idle();
        set_config(24'd4096, 24'd0, 24'd0, 24'hA5A5A5);
        trace_line(16'sd0, 16'sd4095, 16'sd1, 16'sd4096, 1);
    endtask

    // mostly complete short lines, some cut short, some long noise lines and stray steps
    task automatic random_traffic(input int count);
        int stop_at, kind, span, steps;
        logic signed [COORD_W-1:0] sx, sy, ex, ey;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 7)
            begin
                trace_line(rand_word(), rand_word(), rand_word(), rand_word(),
                           $urandom_range(0, 6));
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 3))
                    send_item(FUNC_STEP, rand_word(), rand_word(), rand_word(), rand_word());
            end
            else
            begin
                span = $urandom_range(0, 24);
                sx = near_canvas();
                sy = near_canvas();
                ex = COORD_W'(int'(sx) + int'($urandom_range(0, 2 * span)) - span);
                ey = COORD_W'(int'(sy) + int'($urandom_range(0, 2 * span)) - span);
                steps = line_steps(sx, sy, ex, ey);
                if (kind == 9)
                    steps = $urandom_range(0, steps);
                else if ($urandom_range(0, 3) == 0)
                    steps += $urandom_range(1, 2);
                trace_line(sx, sy, ex, ey, steps);
            end
        end
    endtask

    // random phases, each under its own register setting; the last runs without gaps
    task automatic test_random_phases();
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_config(24'd1, 24'd1, 24'd1, 24'h000000);
                1: set_config(24'd4096, 24'd4, 24'd65535, 24'hFFFFFF);
                PHASE_COUNT - 1:
                    set_config(24'(CANVAS_RESET), 24'(BPP_RESET), 24'(STRIDE_RESET),
                               24'(COLOR_RESET));
                default:
                    set_config(CFG_DATA_W'($urandom_range(1, (ph == 2) ? 64 : 4096)),
                               CFG_DATA_W'($urandom_range(1, 4)),
                               CFG_DATA_W'($urandom_range(0, 65535)),
                               CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
            endcase
            traffic_gaps = (ph != PHASE_COUNT - 1);
            random_traffic(PHASE_ITEMS);
        end
    endtask

    task automatic finish_run();
        wait_idle();
        $display("%0d items sent, %0d lines started, %0d points checked, %0d register settings",
                 items_sent, lines_started, points_checked, settings_used);
        $display("%0d bad or unexpected points", mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CANVAS_SIZE;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_START;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        clear_stepper();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        traffic_gaps = 1'b1;
        test_after_reset();
        test_line_shapes();
        test_canvas_borders();
        test_register_extremes();
        test_random_phases();
        finish_run();
    end

    // output stall in random bursts
    always @(negedge clk)
    begin
        if (!rst_n || !traffic_gaps)
            out_stall <= 1'b0;
        else if (stall_burst > 0)
        begin
            out_stall <= 1'b1;
            stall_burst--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_burst = $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        line_point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            points_checked++;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point x=%0d y=%0d", point_x, point_y);
            end
            else
            begin
                want = expected_points.pop_front();
                if (point_x !== want.x || point_y !== want.y || byte_address !== want.addr ||
                    write_enable !== want.we || color_out !== want.color || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("point %0d expected x=%0d y=%0d addr=%h we=%b color=%h last=%b",
                                 points_checked, want.x, want.y, want.addr, want.we,
                                 want.color, want.last);
                        $display("point %0d got      x=%0d y=%0d addr=%h we=%b color=%h last=%b",
                                 points_checked, point_x, point_y, byte_address, write_enable,
                                 color_out, last);
                    end
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no item moved for %0d cycles, %0d points outstanding",
                         QUIET_LIMIT, expected_points.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
